/* src/foot_contact_and_pressure_center_top_defines.svh */
// Assertion macros for the port-level checker of the foot contact block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FOOT_CONTACT_AND_PRESSURE_CENTER_TOP_DEFINES_SVH
`define FOOT_CONTACT_AND_PRESSURE_CENTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcp: next-cycle check failed");

`endif

/* src/fcp_pkg.sv */
// Shared types, codes and sensor position table of the foot contact block.
// No dependencies; every other source file but fcp_ram and the macros header imports this package.
`timescale 1ns / 1ps

package fcp_pkg;

  localparam int READ_W = 16;   // one force reading, unsigned Q8.8 kg
  localparam int SUM_W  = 18;   // sum of four readings of one foot
  localparam int CFG_IDX_W = 4;

  typedef logic [7:0][READ_W-1:0] frame_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_OFFSET = 4'd0,
    REG_TOTAL_MASS    = 4'd1
  } reg_idx_t;

  // Where the reported center of pressure came from.
  typedef enum logic [1:0] {
    SRC_HELD  = 2'd0,
    SRC_LEFT  = 2'd1,
    SRC_RIGHT = 2'd2
  } src_t;

  // Window unit status toward the controller.
  typedef struct packed {
    logic             done;
    logic             left_contact;
    logic             right_contact;
    logic [SUM_W-1:0] left_sum;
    logic [SUM_W-1:0] right_sum;
  } win_stat_t;

  // Request to the center-of-pressure unit.
  typedef struct packed {
    logic             start;
    logic             foot;     // 0 left, 1 right
    logic [SUM_W-1:0] den;
  } cop_req_t;

  // Result of the center-of-pressure unit.
  typedef struct packed {
    logic               done;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } cop_res_t;

  // Sensor positions in signed Q8.8 mm; axis 0 is forward, 1 is sideways.
  // Sensor order is front-left, front-right, rear-left, rear-right.
  function automatic logic signed [15:0] sensor_pos(logic foot, logic axis,
                                                    logic [1:0] idx);
    logic signed [15:0] p;
    case ({foot, axis, idx})
      4'b0000: p = 16'sd17984;
      4'b0001: p = 16'sd17984;
      4'b0010: p = -16'sd7744;
      4'b0011: p = -16'sd7590;
      4'b0100: p = 16'sd7654;
      4'b0101: p = -16'sd5914;
      4'b0110: p = 16'sd7654;
      4'b0111: p = -16'sd4890;
      4'b1000: p = 16'sd17984;
      4'b1001: p = 16'sd17984;
      4'b1010: p = -16'sd7744;
      4'b1011: p = -16'sd7590;
      4'b1100: p = 16'sd5914;
      4'b1101: p = -16'sd7654;
      4'b1110: p = 16'sd4890;
      default: p = -16'sd7654;
    endcase
    return p;
  endfunction

endpackage

/* src/fcp_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fcp_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/fcp_window.sv */
// Per-foot ring of recent foot sums, running window totals and contact test.
// Depends on fcp_pkg and fcp_ram (one RAM holds both feet's rings side by side).
`timescale 1ns / 1ps

module fcp_window #(
  parameter int WINDOW = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  fcp_pkg::frame_t           frame,
  input  logic signed [15:0]        weight_offset,
  input  logic [15:0]               total_mass,
  output fcp_pkg::win_stat_t        stat
);
  import fcp_pkg::*;

  localparam int TW = SUM_W + $clog2(WINDOW);
  localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW = $clog2(WINDOW + 1);
  localparam int CW = TW + 3;
  localparam logic signed [CW-1:0] WIN_S = CW'(WINDOW);

  logic [PW-1:0]      pos_r;
  logic [FW-1:0]      fill_r;
  logic [TW-1:0]      ltot_r, rtot_r;
  logic [TW-1:0]      ltot_nxt, rtot_nxt;
  logic [SUM_W-1:0]   lsum_r, rsum_r;
  logic [SUM_W-1:0]   lsum_c, rsum_c;
  logic               rd_pend_r, upd_r, done_r;
  logic               lc_r, rc_r;
  logic [2*SUM_W-1:0] rdata;
  logic               full;
  logic signed [CW-1:0] off_scaled, mass_scaled, lhs_l, lhs_r;

  // Foot sums of the new frame.
  assign lsum_c = SUM_W'(frame[0]) + SUM_W'(frame[1]) + SUM_W'(frame[2]) + SUM_W'(frame[3]);
  assign rsum_c = SUM_W'(frame[4]) + SUM_W'(frame[5]) + SUM_W'(frame[6]) + SUM_W'(frame[7]);

  // The oldest entry is read on start and overwritten in the next cycle.
  // Items are processed one at a time, so a read never meets a pending write.
  fcp_ram #(
    .WIDTH (2 * SUM_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (rd_pend_r),
    .waddr (pos_r),
    .wdata ({rsum_r, lsum_r}),
    .re    (start),
    .raddr (pos_r),
    .rdata (rdata)
  );

  assign full = (fill_r == FW'(WINDOW));

  // Retire the oldest sum once the ring is full, then add the newest.
  assign ltot_nxt = ltot_r - (full ? TW'(rdata[SUM_W-1:0]) : '0) + TW'(lsum_r);
  assign rtot_nxt = rtot_r - (full ? TW'(rdata[2*SUM_W-1:SUM_W]) : '0) + TW'(rsum_r);

  // Exact contact test: total + offset*WINDOW >= mass*WINDOW.
  assign off_scaled  = $signed({{(CW-16){weight_offset[15]}}, weight_offset}) * WIN_S;
  assign mass_scaled = $signed({{(CW-16){1'b0}}, total_mass}) * WIN_S;
  assign lhs_l = $signed({{(CW-TW){1'b0}}, ltot_r}) + off_scaled;
  assign lhs_r = $signed({{(CW-TW){1'b0}}, rtot_r}) + off_scaled;

  // Pipeline of the three window steps and ring bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      fill_r    <= '0;
      ltot_r    <= '0;
      rtot_r    <= '0;
      rd_pend_r <= 1'b0;
      upd_r     <= 1'b0;
      done_r    <= 1'b0;
      lc_r      <= 1'b0;
      rc_r      <= 1'b0;
    end else begin
      rd_pend_r <= start;
      upd_r     <= rd_pend_r;
      done_r    <= upd_r;
      if (rd_pend_r) begin
        ltot_r <= ltot_nxt;
        rtot_r <= rtot_nxt;
        pos_r  <= (pos_r == PW'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
        if (!full) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (upd_r) begin
        lc_r <= full && (lhs_l >= mass_scaled);
        rc_r <= full && (lhs_r >= mass_scaled);
      end
    end
  end

  // Foot sums of the current frame.
  always_ff @(posedge clk) begin
    if (start) begin
      lsum_r <= lsum_c;
      rsum_r <= rsum_c;
    end
  end

  assign stat.done          = done_r;
  assign stat.left_contact  = lc_r;
  assign stat.right_contact = rc_r;
  assign stat.left_sum      = lsum_r;
  assign stat.right_sum     = rsum_r;

endmodule

/* src/fcp_cop.sv */
// Center-of-pressure unit: eight weighted products through one
// multiplier, then a shared restoring divider for both coordinates.
// Depends on fcp_pkg.
`timescale 1ns / 1ps

module fcp_cop (
  input  logic              clk,
  input  logic              rst_n,
  input  fcp_pkg::cop_req_t req,
  input  fcp_pkg::frame_t   frame,
  output fcp_pkg::cop_res_t res
);
  import fcp_pkg::*;

  localparam int PROD_W = 33;
  localparam int ACC_W  = 35;
  localparam int MAG_W  = 34;
  localparam int Q_W    = 16;
  localparam int REM_W  = MAG_W - Q_W;

  typedef enum logic [4:0] {
    C_IDLE  = 5'b00001,
    C_MAC   = 5'b00010,
    C_DRAIN = 5'b00100,
    C_LOAD  = 5'b01000,
    C_DIV   = 5'b10000
  } cop_state_t;

  cop_state_t state_r;
  logic [2:0]              idx_r, prod_idx_r;
  logic                    prod_vld_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_x_r, acc_y_r, num;
  logic [ACC_W-1:0]        absn;
  logic [MAG_W-1:0]        dvd;
  logic                    axis_r, neg_r, done_r;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [REM_W:0]          trial, diff;
  logic                    ge;
  logic [Q_W-1:0]          lo_r, q_r, q_nxt, qs;
  logic [3:0]              cnt_r;
  logic signed [15:0]      coef, x_r, y_r;
  logic [READ_W-1:0]       rd;

  // One product per cycle: position constant times one reading.
  assign coef     = sensor_pos(req.foot, idx_r[2], idx_r[1:0]);
  assign rd       = frame[{req.foot, idx_r[1:0]}];
  assign prod_nxt = PROD_W'(coef) * PROD_W'($signed({1'b0, rd}));

  // Dividend magnitude with half the divisor added for round-to-nearest.
  assign num  = axis_r ? acc_y_r : acc_x_r;
  assign absn = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign dvd  = absn[MAG_W-1:0] + MAG_W'(req.den >> 1);

  // One restoring division step.
  assign trial   = {rem_r, lo_r[Q_W-1]};
  assign diff    = trial - {1'b0, req.den};
  assign ge      = (trial >= {1'b0, req.den});
  assign rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
  assign q_nxt   = {q_r[Q_W-2:0], ge};
  // The quotient is a weighted average of the positions, so it always fits.
  assign qs      = neg_r ? Q_W'(-q_nxt) : q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= C_IDLE;
      prod_vld_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (req.start) begin
            idx_r      <= '0;
            acc_x_r    <= '0;
            acc_y_r    <= '0;
            prod_vld_r <= 1'b0;
            state_r    <= C_MAC;
          end
        end
        C_MAC: begin
          prod_r     <= prod_nxt;
          prod_idx_r <= idx_r;
          prod_vld_r <= 1'b1;
          idx_r      <= idx_r + 1'b1;
          if (idx_r == 3'd7) begin
            state_r <= C_DRAIN;
          end
        end
        C_DRAIN: begin
          prod_vld_r <= 1'b0;
          axis_r     <= 1'b0;
          state_r    <= C_LOAD;
        end
        C_LOAD: begin
          neg_r   <= num[ACC_W-1];
          rem_r   <= dvd[MAG_W-1:Q_W];
          lo_r    <= dvd[Q_W-1:0];
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= C_DIV;
        end
        C_DIV: begin
          rem_r <= rem_nxt;
          lo_r  <= {lo_r[Q_W-2:0], 1'b0};
          q_r   <= q_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 4'(Q_W - 1)) begin
            if (!axis_r) begin
              x_r     <= qs;
              axis_r  <= 1'b1;
              state_r <= C_LOAD;
            end else begin
              y_r     <= qs;
              done_r  <= 1'b1;
              state_r <= C_IDLE;
            end
          end
        end
        default: state_r <= C_IDLE;
      endcase
      // Accumulate the registered product into its coordinate.
      if (prod_vld_r) begin
        if (prod_idx_r[2]) begin
          acc_y_r <= acc_y_r + ACC_W'(prod_r);
        end else begin
          acc_x_r <= acc_x_r + ACC_W'(prod_r);
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.x    = x_r;
  assign res.y    = y_r;

endmodule

/* src/foot_contact_and_pressure_center_top.sv */
// Top level of the foot contact and center-of-pressure block.
// Depends on fcp_pkg, fcp_window (rings in RAM) and fcp_cop (MAC and divider).
`timescale 1ns / 1ps

// One sensor frame is taken at a time and gives one result word. When no
// center of pressure is computed, a frame passes through the ring read,
// the window update and the contact test. When exactly one foot is in
// contact with a nonzero foot sum, the single multiply-accumulate unit
// also forms eight products and the shared restoring divider makes two
// 16-step passes, one per coordinate. The next frame is accepted
// as soon as the current one has moved into the output register, while that
// result still waits to be taken. Configuration writes are always ready.
module foot_contact_and_pressure_center_top #(
  parameter int WINDOW = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [15:0]                    in_left_front_left,
  input  logic [15:0]                    in_left_front_right,
  input  logic [15:0]                    in_left_rear_left,
  input  logic [15:0]                    in_left_rear_right,
  input  logic [15:0]                    in_right_front_left,
  input  logic [15:0]                    in_right_front_right,
  input  logic [15:0]                    in_right_rear_left,
  input  logic [15:0]                    in_right_rear_right,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_left_contact,
  output logic                           out_right_contact,
  output logic signed [15:0]             out_pressure_x,
  output logic signed [15:0]             out_pressure_y,
  output logic [1:0]                     out_pressure_source,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import fcp_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_WIN  = 4'b0010,
    T_COP  = 4'b0100,
    T_OUT  = 4'b1000
  } top_state_t;

  top_state_t state_r;
  frame_t     frame_r;
  logic       win_start_r, cop_start_r;
  logic signed [15:0] offset_r, held_x_r, held_y_r;
  logic [15:0] mass_r;
  src_t       src_r;
  logic       out_valid_r;
  win_stat_t  wstat;
  cop_req_t   creq;
  cop_res_t   cres;

  assign in_ready  = (state_r == T_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      mass_r   <= 16'd1280;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WEIGHT_OFFSET: offset_r <= cfg_wdata;
        REG_TOTAL_MASS:    mass_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame capture on acceptance.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_r <= {in_right_rear_right, in_right_rear_left, in_right_front_right,
                  in_right_front_left, in_left_rear_right, in_left_rear_left,
                  in_left_front_right, in_left_front_left};
    end
  end

  fcp_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (win_start_r),
    .frame         (frame_r),
    .weight_offset (offset_r),
    .total_mass    (mass_r),
    .stat          (wstat)
  );

  assign creq.start = cop_start_r;
  assign creq.foot  = (src_r == SRC_RIGHT);
  assign creq.den   = (src_r == SRC_RIGHT) ? wstat.right_sum : wstat.left_sum;

  fcp_cop u_cop (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .frame (frame_r),
    .res   (cres)
  );

  // Frame sequencer and held center of pressure.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      win_start_r <= 1'b0;
      cop_start_r <= 1'b0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      src_r       <= SRC_HELD;
      out_valid_r <= 1'b0;
    end else begin
      win_start_r <= 1'b0;
      cop_start_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_IDLE: begin
          if (in_valid) begin
            win_start_r <= 1'b1;
            state_r     <= T_WIN;
          end
        end
        T_WIN: begin
          if (wstat.done) begin
            if (wstat.left_contact && !wstat.right_contact && wstat.left_sum != '0) begin
              src_r       <= SRC_LEFT;
              cop_start_r <= 1'b1;
              state_r     <= T_COP;
            end else if (!wstat.left_contact && wstat.right_contact &&
                         wstat.right_sum != '0) begin
              src_r       <= SRC_RIGHT;
              cop_start_r <= 1'b1;
              state_r     <= T_COP;
            end else begin
              src_r   <= SRC_HELD;
              state_r <= T_OUT;
            end
          end
        end
        T_COP: begin
          if (cres.done) begin
            held_x_r <= cres.x;
            held_y_r <= cres.y;
            state_r  <= T_OUT;
          end
        end
        T_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (state_r == T_OUT && (!out_valid_r || out_ready)) begin
      out_left_contact    <= wstat.left_contact;
      out_right_contact   <= wstat.right_contact;
      out_pressure_x      <= held_x_r;
      out_pressure_y      <= held_y_r;
      out_pressure_source <= src_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* src/fcp_checker.sv */
// Port-level checks of the foot contact block, bound to its top level.
// Depends on fcp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "foot_contact_and_pressure_center_top_defines.svh"

module fcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_left_contact,
  input logic        out_right_contact,
  input logic [15:0] out_pressure_x,
  input logic [15:0] out_pressure_y,
  input logic [1:0]  out_pressure_source
);
  import fcp_pkg::*;

  // A stalled result word keeps its center and source fields.
  `FCP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pressure_x) && $stable(out_pressure_y) && $stable(out_pressure_source))

  // A center taken from the left foot means only the left foot is down.
  `FCP_ASSERT_SAME(a_src_left, out_valid && out_pressure_source == SRC_LEFT, out_left_contact && !out_right_contact)

  // A center taken from the right foot means only the right foot is down.
  `FCP_ASSERT_SAME(a_src_right, out_valid && out_pressure_source == SRC_RIGHT, out_right_contact && !out_left_contact)

  // Frames are processed one at a time: no acceptance right after another.
  `FCP_ASSERT_NEXT(a_one_frame, in_valid && in_ready, !in_ready)

endmodule

bind foot_contact_and_pressure_center_top fcp_checker u_fcp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_left_contact    (out_left_contact),
  .out_right_contact   (out_right_contact),
  .out_pressure_x      (out_pressure_x),
  .out_pressure_y      (out_pressure_y),
  .out_pressure_source (out_pressure_source)
);

/* bench/foot_contact_and_pressure_center_checker.sv */
// Checker for the foot contact and center-of-pressure block: watches the three channels,
// predicts each result word from the accepted sensor frames and compares it field by field.
// Depends on fcp_pkg for the register indexes and source codes.
`timescale 1ns / 1ps

module foot_contact_and_pressure_center_checker #(
  parameter int WINDOW = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [15:0]                    in_left_front_left,
  input  logic [15:0]                    in_left_front_right,
  input  logic [15:0]                    in_left_rear_left,
  input  logic [15:0]                    in_left_rear_right,
  input  logic [15:0]                    in_right_front_left,
  input  logic [15:0]                    in_right_front_right,
  input  logic [15:0]                    in_right_rear_left,
  input  logic [15:0]                    in_right_rear_right,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_left_contact,
  input  logic                           out_right_contact,
  input  logic signed [15:0]             out_pressure_x,
  input  logic signed [15:0]             out_pressure_y,
  input  logic [1:0]                     out_pressure_source,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_wdata,
  output int                             mismatches,
  output int                             words_due
);
  import fcp_pkg::*;

  // One predicted result word.
  typedef struct {
    logic               left_on;
    logic               right_on;
    logic signed [15:0] cop_x;
    logic signed [15:0] cop_y;
    src_t               source;
  } contact_word_t;

  contact_word_t contact_words_due [$];

  // Predictor state: configuration, the two force rings and the held center.
  logic signed [15:0] weight_offset_q;
  logic [15:0]        total_mass_q;
  logic [17:0]        left_ring [WINDOW];
  logic [17:0]        right_ring [WINDOW];
  logic [20:0]        left_total;
  logic [20:0]        right_total;
  int                 ring_pos;
  int                 fill_cnt;
  logic signed [15:0] cop_x_q;
  logic signed [15:0] cop_y_q;

  // Forward sensor position in Q8.8 mm; both feet share it.
  function automatic longint fwd_mm(int s);
    case (s)
      0, 1:    return 17984;
      2:       return -7744;
      default: return -7590;
    endcase
  endfunction

  // Sideways sensor position in Q8.8 mm; the feet are not mirror images.
  function automatic longint side_mm(bit right_foot, int s);
    if (!right_foot) begin
      case (s)
        0, 2:    return 7654;
        1:       return -5914;
        default: return -4890;
      endcase
    end
    case (s)
      0:       return 5914;
      2:       return 4890;
      default: return -7654;
    endcase
  endfunction

  // The ring must be full, then the unrounded window average plus the offset
  // is compared with the mass, scaled up by the window length.
  function automatic bit on_ground(logic [20:0] total);
    longint lhs;
    longint rhs;
    lhs = longint'(total) + longint'(weight_offset_q) * WINDOW;
    rhs = longint'(total_mass_q) * WINDOW;
    return (fill_cnt >= WINDOW) && (lhs >= rhs);
  endfunction

  // Division rounded to nearest with ties away from zero, saturated to 16 bits.
  function automatic logic signed [15:0] round_quotient(longint num, longint den);
    bit     neg;
    longint mag;
    longint q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag + den / 2) / den;
    if (!neg && q > 32767) return 16'sh7FFF;
    if (neg && q > 32768) return 16'sh8000;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  // Weighted sensor positions of one foot over its force sum.
  function automatic void center_of(bit right_foot, logic [15:0] rd [8], logic [17:0] den);
    longint nx;
    longint ny;
    int     base;
    nx = 0;
    ny = 0;
    base = right_foot ? 4 : 0;
    for (int s = 0; s < 4; s++) begin
      nx += fwd_mm(s) * longint'(rd[base + s]);
      ny += side_mm(right_foot, s) * longint'(rd[base + s]);
    end
    cop_x_q = round_quotient(nx, longint'(den));
    cop_y_q = round_quotient(ny, longint'(den));
  endfunction

  // Advances the rings by one frame and returns the word the block must give.
  function automatic contact_word_t next_contact_word(logic [15:0] rd [8]);
    contact_word_t w;
    logic [17:0]   lsum;
    logic [17:0]   rsum;
    lsum = '0;
    rsum = '0;
    for (int s = 0; s < 4; s++) begin
      lsum += rd[s];
      rsum += rd[4 + s];
    end
    if (fill_cnt >= WINDOW) begin
      left_total -= left_ring[ring_pos];
      right_total -= right_ring[ring_pos];
    end
    left_ring[ring_pos] = lsum;
    right_ring[ring_pos] = rsum;
    left_total += lsum;
    right_total += rsum;
    ring_pos = (ring_pos + 1) % WINDOW;
    if (fill_cnt < WINDOW) fill_cnt++;

    w.left_on = on_ground(left_total);
    w.right_on = on_ground(right_total);
    w.source = SRC_HELD;
    // A center is computed only for a single stance foot carrying some force.
    if (w.left_on && !w.right_on && lsum != 0) begin
      center_of(1'b0, rd, lsum);
      w.source = SRC_LEFT;
    end else if (!w.left_on && w.right_on && rsum != 0) begin
      center_of(1'b1, rd, rsum);
      w.source = SRC_RIGHT;
    end
    w.cop_x = cop_x_q;
    w.cop_y = cop_y_q;
    return w;
  endfunction

  task automatic reset_model();
    contact_words_due.delete();
    weight_offset_q = '0;
    total_mass_q = 16'd1280;
    for (int i = 0; i < WINDOW; i++) begin
      left_ring[i] = '0;
      right_ring[i] = '0;
    end
    left_total = '0;
    right_total = '0;
    ring_pos = 0;
    fill_cnt = 0;
    cop_x_q = '0;
    cop_y_q = '0;
  endtask

  task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%s mismatch: expected %h, got %h", field, want, got);
    end
  endtask

  // Compares an accepted result word with the oldest prediction.
  task automatic check_word();
    contact_word_t w;
    if (contact_words_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result word accepted with no frame outstanding");
      return;
    end
    w = contact_words_due.pop_front();
    compare_field("left_contact", 16'(w.left_on), 16'(out_left_contact));
    compare_field("right_contact", 16'(w.right_on), 16'(out_right_contact));
    compare_field("pressure_x", w.cop_x, out_pressure_x);
    compare_field("pressure_y", w.cop_y, out_pressure_y);
    compare_field("pressure_source", 16'(w.source), 16'(out_pressure_source));
  endtask

  // Sample every channel at the clock edge, results before new frames.
  always @(posedge clk) begin
    logic [15:0] rd [8];
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WEIGHT_OFFSET: weight_offset_q = cfg_wdata;
          REG_TOTAL_MASS:    total_mass_q = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_word();
      if (in_valid && in_ready) begin
        rd[0] = in_left_front_left;
        rd[1] = in_left_front_right;
        rd[2] = in_left_rear_left;
        rd[3] = in_left_rear_right;
        rd[4] = in_right_front_left;
        rd[5] = in_right_front_right;
        rd[6] = in_right_rear_left;
        rd[7] = in_right_rear_right;
        contact_words_due.push_back(next_contact_word(rd));
      end
    end
    words_due = contact_words_due.size();
  end

endmodule

/* bench/foot_contact_and_pressure_center_top_tb.sv */
// Testbench top for the foot contact and center-of-pressure block: makes the sensor
// frames, register writes and receiver stalls, and gives the verdict.
// Depends on fcp_pkg, the block itself and foot_contact_and_pressure_center_checker.
`timescale 1ns / 1ps

module foot_contact_and_pressure_center_top_tb;
  import fcp_pkg::*;

  localparam int WINDOW         = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(9);

  // How heavily one foot is loaded during a stretch of frames.
  typedef enum {LOAD_ZERO, LOAD_LIGHT, LOAD_NEAR, LOAD_HEAVY, LOAD_FULLSCALE, LOAD_NOISE} load_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [15:0]           in_left_front_left;
  logic [15:0]           in_left_front_right;
  logic [15:0]           in_left_rear_left;
  logic [15:0]           in_left_rear_right;
  logic [15:0]           in_right_front_left;
  logic [15:0]           in_right_front_right;
  logic [15:0]           in_right_rear_left;
  logic [15:0]           in_right_rear_right;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_left_contact;
  logic                  out_right_contact;
  logic signed [15:0]    out_pressure_x;
  logic signed [15:0]    out_pressure_y;
  logic [1:0]            out_pressure_source;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [15:0]           cfg_wdata;

  int mismatches;
  int words_due;
  int tx_pct;
  int rx_pct;
  int foot_base;
  int sent_in_phase;
  int idle_cycles;
  int hold_reqs;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  foot_contact_and_pressure_center_top #(.WINDOW(WINDOW)) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_left_front_left   (in_left_front_left),
    .in_left_front_right  (in_left_front_right),
    .in_left_rear_left    (in_left_rear_left),
    .in_left_rear_right   (in_left_rear_right),
    .in_right_front_left  (in_right_front_left),
    .in_right_front_right (in_right_front_right),
    .in_right_rear_left   (in_right_rear_left),
    .in_right_rear_right  (in_right_rear_right),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_left_contact     (out_left_contact),
    .out_right_contact    (out_right_contact),
    .out_pressure_x       (out_pressure_x),
    .out_pressure_y       (out_pressure_y),
    .out_pressure_source  (out_pressure_source),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  foot_contact_and_pressure_center_checker #(.WINDOW(WINDOW)) i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_left_front_left   (in_left_front_left),
    .in_left_front_right  (in_left_front_right),
    .in_left_rear_left    (in_left_rear_left),
    .in_left_rear_right   (in_left_rear_right),
    .in_right_front_left  (in_right_front_left),
    .in_right_front_right (in_right_front_right),
    .in_right_rear_left   (in_right_rear_left),
    .in_right_rear_right  (in_right_rear_right),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_left_contact     (out_left_contact),
    .out_right_contact    (out_right_contact),
    .out_pressure_x       (out_pressure_x),
    .out_pressure_y       (out_pressure_y),
    .out_pressure_source  (out_pressure_source),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .mismatches           (mismatches),
    .words_due            (words_due)
  );

  // Gap length: mostly a few cycles, sometimes longer, rarely very long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(16, 4);
    return $urandom_range(120, 30);
  endfunction

  // One force reading for the given load, scaled to the current threshold.
  function automatic logic [15:0] pick_reading(load_t mode);
    int lo;
    int hi;
    case (mode)
      LOAD_ZERO:      return 16'h0000;
      LOAD_FULLSCALE: return 16'hFFFF;
      LOAD_NOISE:     return 16'($urandom_range(16'hFFFF, 0));
      LOAD_LIGHT: begin
        lo = 0;
        hi = foot_base / 8;
      end
      LOAD_NEAR: begin
        lo = foot_base * 7 / 8;
        hi = foot_base * 9 / 8;
      end
      default: begin
        lo = foot_base;
        hi = foot_base * 3 / 2;
      end
    endcase
    if (hi > 16'hFFFF) hi = 16'hFFFF;
    if (lo > hi) lo = hi;
    return 16'($urandom_range(hi, lo));
  endfunction

  // Now and then a foot reads nothing or saturates for a single frame.
  function automatic load_t jitter(load_t mode);
    int r;
    r = $urandom_range(99);
    if (r < 3) return LOAD_ZERO;
    if (r < 5) return LOAD_FULLSCALE;
    return mode;
  endfunction

  // Offers one frame and holds it until the block takes the word.
  task automatic send_frame(input logic [15:0] rd [8]);
    in_left_front_left   <= rd[0];
    in_left_front_right  <= rd[1];
    in_left_rear_left    <= rd[2];
    in_left_rear_right   <= rd[3];
    in_right_front_left  <= rd[4];
    in_right_front_right <= rd[5];
    in_right_rear_left   <= rd[6];
    in_right_rear_right  <= rd[7];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_in_phase++;
  endtask

  task automatic tx_gap();
    int n;
    if ($urandom_range(99) < tx_pct) begin
      n = pick_gap();
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Frames with every sensor of a foot at the same reading.
  task automatic send_uniform(input logic [15:0] left_v, input logic [15:0] right_v, input int n);
    logic [15:0] rd [8];
    for (int s = 0; s < 4; s++) begin
      rd[s] = left_v;
      rd[4 + s] = right_v;
    end
    repeat (n) begin
      send_frame(rd);
      tx_gap();
    end
  endtask

  // A stretch of frames with each foot in one stance.
  task automatic run_stance(input load_t lmode, input load_t rmode, input int n);
    logic [15:0] rd [8];
    load_t       lm;
    load_t       rm;
    repeat (n) begin
      lm = jitter(lmode);
      rm = jitter(rmode);
      for (int s = 0; s < 4; s++) begin
        rd[s] = pick_reading(lm);
        rd[4 + s] = pick_reading(rm);
      end
      send_frame(rd);
      tx_gap();
    end
  endtask

  // Mostly single-support gait, with some double support, flight and noise.
  task automatic random_stance();
    int r;
    int n;
    r = $urandom_range(99);
    n = $urandom_range(24, 4);
    if (r < 38)      run_stance(LOAD_HEAVY, LOAD_LIGHT, n);
    else if (r < 76) run_stance(LOAD_LIGHT, LOAD_HEAVY, n);
    else if (r < 84) run_stance(LOAD_HEAVY, LOAD_HEAVY, n);
    else if (r < 90) run_stance(LOAD_NEAR, LOAD_NEAR, n);
    else if (r < 95) run_stance(LOAD_LIGHT, LOAD_LIGHT, n);
    else             run_stance(LOAD_NOISE, LOAD_NOISE, n);
  endtask

  // Lets the block drain: every predicted word taken, then a latency margin.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Receiver stops taking words while the sender keeps pushing frames.
  task automatic hold_off();
    int saved;
    saved = tx_pct;
    tx_pct = 0;
    hold_reqs++;
    run_stance(LOAD_HEAVY, LOAD_LIGHT, 12);
    tx_pct = saved;
  endtask

  function automatic int phase_quota(int p);
    case (p)
      0, 3, 5: return 180;
      1, 4:    return 150;
      default: return 60;
    endcase
  endfunction

  // Register settings and idling of each random phase, extremes included.
  task automatic program_phase(input int p);
    logic signed [15:0] ofs;
    logic [15:0]        mass;
    int                 target;
    case (p)
      0: begin
        ofs = 16'sd0; mass = 16'd1280; rx_pct = 30; tx_pct = 30;
      end
      1: begin
        ofs = 16'sh8000; mass = 16'hFFFF; rx_pct = 0; tx_pct = 0;
      end
      2: begin
        ofs = 16'sh7FFF; mass = 16'h0000; rx_pct = 50; tx_pct = 10;
      end
      3: begin
        ofs = 16'($signed($urandom_range(4095, 0)) - 2048);
        mass = 16'($urandom_range(30000, 512));
        rx_pct = 20; tx_pct = 40;
      end
      4: begin
        ofs = 16'($urandom_range(16'hFFFF, 0));
        mass = 16'($urandom_range(16'hFFFF, 0));
        rx_pct = 60; tx_pct = 60;
      end
      default: begin
        ofs = 16'sd0; mass = 16'd2560; rx_pct = 25; tx_pct = 0;
      end
    endcase
    cfg_write(REG_WEIGHT_OFFSET, ofs);
    cfg_write(REG_TOTAL_MASS, mass);
    // A write to an unmapped index must leave both registers alone.
    if (p == 5) cfg_write(REG_UNMAPPED, 16'($urandom_range(16'hFFFF, 0)));
    cfg_valid <= 1'b0;
    target = int'(mass) - int'(ofs);
    if (target < 16) target = 16;
    if (target > 262140) target = 262140;
    foot_base = target / 4;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done < hold_reqs) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(99) < rx_pct) begin
        out_ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long with no word moving on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus: directed frames, then random phases, then the verdict.
  initial begin
    logic [15:0] rd [8];
    bit          held;
    bit          paused;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_left_front_left <= '0;
    in_left_front_right <= '0;
    in_left_rear_left <= '0;
    in_left_rear_right <= '0;
    in_right_front_left <= '0;
    in_right_front_right <= '0;
    in_right_rear_left <= '0;
    in_right_rear_right <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WEIGHT_OFFSET;
    cfg_wdata <= '0;
    rx_pct = 20;
    tx_pct = 20;
    foot_base = 320;
    sent_in_phase = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Ring filling: no contact until eight frames, then both feet down.
    send_uniform(16'h0000, 16'h0000, 1);
    send_uniform(16'hFFFF, 16'hFFFF, 7);
    // Right foot lifts: left alone in contact, center on a rounding tie.
    send_uniform(16'hFFFF, 16'h0000, 8);
    // Left still in contact on its window but reads zero: center holds.
    send_uniform(16'h0000, 16'h0000, 1);
    // Uneven right foot load while the left window drains.
    for (int s = 0; s < 4; s++) rd[s] = 16'h0000;
    rd[4] = 16'hFFFF;
    rd[5] = 16'h0001;
    rd[6] = 16'h0000;
    rd[7] = 16'h8000;
    repeat (8) begin
      send_frame(rd);
      tx_gap();
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      program_phase(p);
      sent_in_phase = 0;
      held = 1'b0;
      paused = 1'b0;
      while (sent_in_phase < phase_quota(p)) begin
        random_stance();
        if (p == 3 && !held && sent_in_phase >= 40) begin
          hold_off();
          held = 1'b1;
        end
        if (p == 5 && !paused && sent_in_phase >= 60) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
